// ----- rtl/dite_pkg.sv -----
// Package: TERC4 table, BCH parity helper and shared constants for the data island encoder.
package dite_pkg;

  localparam int unsigned ISLAND_WORDS = 36;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned LANE_W       = 10;
  localparam int unsigned WORD_W       = 3 * LANE_W;

  localparam logic [IDX_W-1:0]  IDX_LAST       = IDX_W'(ISLAND_WORDS - 1);
  localparam logic [IDX_W-1:0]  IDX_DATA_FIRST = 6'd2;
  localparam logic [IDX_W-1:0]  IDX_DATA_END   = 6'd34;

  localparam logic [LANE_W-1:0] GUARD_SYMBOL   = 10'h133;
  localparam logic [1:0]        GUARD_CODE_HI  = 2'b11;   // 0xC with the sync bits below
  localparam logic [7:0]        BCH_POLY       = 8'h83;
  localparam logic [31:0]       SHUF_MASK_A    = 32'h00aa00aa;
  localparam logic [31:0]       SHUF_MASK_B    = 32'h0000cccc;

  // Subpackets with their parity byte appended: byte 7 is parity.
  typedef logic [3:0][63:0] sub_t;

  function automatic logic [LANE_W-1:0] terc4(input logic [3:0] code);
    logic [LANE_W-1:0] sym;
    case (code)
      4'h0:    sym = 10'h29C;
      4'h1:    sym = 10'h263;
      4'h2:    sym = 10'h2E4;
      4'h3:    sym = 10'h2E2;
      4'h4:    sym = 10'h171;
      4'h5:    sym = 10'h11E;
      4'h6:    sym = 10'h18E;
      4'h7:    sym = 10'h13C;
      4'h8:    sym = 10'h2CC;
      4'h9:    sym = 10'h139;
      4'hA:    sym = 10'h19C;
      4'hB:    sym = 10'h2C6;
      4'hC:    sym = 10'h28E;
      4'hD:    sym = 10'h271;
      4'hE:    sym = 10'h163;
      4'hF:    sym = 10'h2C3;
      default: sym = 10'h29C;
    endcase
    return sym;
  endfunction

  // Byte-wise reflected LFSR over the first nbytes bytes, byte 0 first.
  // Pure XOR network once the constant count is folded in.
  function automatic logic [7:0] bch_calc(input logic [55:0] data, input logic [2:0] nbytes);
    logic [7:0] ecc;
    logic [7:0] s;
    ecc = 8'h00;
    for (int k = 0; k < 7; k++) begin
      if (3'(k) < nbytes) begin
        s = ecc ^ data[8*k +: 8];
        for (int b = 0; b < 8; b++) begin
          if (s[0]) s = (s >> 1) ^ BCH_POLY;
          else      s = s >> 1;
        end
        ecc = s;
      end
    end
    return ecc;
  endfunction

endpackage

// ----- rtl/dite_word.sv -----
// Word formatter: builds one 30-bit three-lane symbol word of the island from the held packet.
module dite_word
  import dite_pkg::*;
(
  input  logic [31:0]       hdr,       // header bytes plus parity in bits 31:24
  input  sub_t              sub,
  input  logic [1:0]        hv,        // line levels: vsync in bit 1, hsync in bit 0
  input  logic [IDX_W-1:0]  idx,
  output logic [WORD_W-1:0] word
);

  logic [IDX_W-1:0]  s_full;
  logic [4:0]        s;
  logic              is_guard;
  logic              hbit;
  logic              flag;
  logic [2:0]        bpos;
  logic [31:0]       v;
  logic [31:0]       t1;
  logic [31:0]       v1;
  logic [31:0]       t2;
  logic [31:0]       v2;
  logic [3:0]        nib1;
  logic [3:0]        nib2;
  logic [LANE_W-1:0] lane0;
  logic [LANE_W-1:0] lane1;
  logic [LANE_W-1:0] lane2;

  assign s_full   = idx - IDX_DATA_FIRST;
  assign s        = s_full[4:0];
  assign is_guard = (idx < IDX_DATA_FIRST) || (idx >= IDX_DATA_END);
  assign hbit     = hdr[s];
  assign flag     = (s != 5'd0);
  assign bpos     = s[4:2];

  assign v = {sub[3][8*bpos +: 8], sub[2][8*bpos +: 8],
              sub[1][8*bpos +: 8], sub[0][8*bpos +: 8]};

  // two delta swaps
  assign t1 = (v ^ (v >> 7)) & SHUF_MASK_A;
  assign v1 = v ^ t1 ^ (t1 << 7);
  assign t2 = (v1 ^ (v1 >> 14)) & SHUF_MASK_B;
  assign v2 = v1 ^ t2 ^ (t2 << 14);

  always_comb begin
    case (s[1:0])
      2'd0: begin
        nib1 = v2[3:0];
        nib2 = v2[11:8];
      end
      2'd1: begin
        nib1 = v2[19:16];
        nib2 = v2[27:24];
      end
      2'd2: begin
        nib1 = v2[7:4];
        nib2 = v2[15:12];
      end
      2'd3: begin
        nib1 = v2[23:20];
        nib2 = v2[31:28];
      end
      default: begin
        nib1 = v2[3:0];
        nib2 = v2[11:8];
      end
    endcase
  end

  always_comb begin
    if (is_guard) begin
      lane0 = terc4({GUARD_CODE_HI, hv});
      lane1 = GUARD_SYMBOL;
      lane2 = GUARD_SYMBOL;
    end else begin
      lane0 = terc4({flag, hbit, hv});
      lane1 = terc4(nib1);
      lane2 = terc4(nib2);
    end
  end

  assign word = {lane2, lane1, lane0};

endmodule

// ----- rtl/data_island_terc4_encoder_core.sv -----
// Top level: data island encoder, packet register, word counter and output register.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------------
//  input   | start, busy        | in_header_bytes, in_subpacket_a..d, in_vsync_on, in_hsync_on
//  result  | out_valid (strobe) | out_symbol_word, out_word_index, out_last_word
//
// One packet gives 36 words, one per cycle, paced by the word counter.
// The first word passes the packet register and then the output register after the transfer.
// busy drops while word 35 is formed, so packets can follow with no gap between islands.
// Reset clears the counter and the strobe; the receiver cannot stall the result channel.
module data_island_terc4_encoder_core
  import dite_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [23:0]       in_header_bytes,
  input  logic [55:0]       in_subpacket_a,
  input  logic [55:0]       in_subpacket_b,
  input  logic [55:0]       in_subpacket_c,
  input  logic [55:0]       in_subpacket_d,
  input  logic              in_vsync_on,
  input  logic              in_hsync_on,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_symbol_word,
  output logic [IDX_W-1:0]  out_word_index,
  output logic              out_last_word
);

  logic              active_r;
  logic              active_nxt;
  logic [IDX_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  cnt_nxt;
  logic [31:0]       hdr_r;
  sub_t              sub_r;
  logic [1:0]        hv_r;
  logic              accept;
  logic [WORD_W-1:0] word;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  assign busy   = active_r && (cnt_r != IDX_LAST);
  assign accept = start && !busy;

  always_comb begin
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    if (accept) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
    end else if (active_r) begin
      if (cnt_r == IDX_LAST) begin
        active_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= active_r;
    end
  end

  // packet register, parity bytes computed on the way in
  always_ff @(posedge clk) begin
    if (accept) begin
      hdr_r    <= {bch_calc({32'd0, in_header_bytes}, 3'd3), in_header_bytes};
      sub_r[0] <= {bch_calc(in_subpacket_a, 3'd7), in_subpacket_a};
      sub_r[1] <= {bch_calc(in_subpacket_b, 3'd7), in_subpacket_b};
      sub_r[2] <= {bch_calc(in_subpacket_c, 3'd7), in_subpacket_c};
      sub_r[3] <= {bch_calc(in_subpacket_d, 3'd7), in_subpacket_d};
      hv_r     <= {~in_vsync_on, ~in_hsync_on};
    end
  end

  dite_word u_word (
    .hdr  (hdr_r),
    .sub  (sub_r),
    .hv   (hv_r),
    .idx  (cnt_r),
    .word (word)
  );

  always_ff @(posedge clk) begin
    out_word_r <= word;
    out_idx_r  <= cnt_r;
    out_last_r <= active_r && (cnt_r == IDX_LAST);
  end

  assign out_valid       = out_valid_r;
  assign out_symbol_word = out_word_r;
  assign out_word_index  = out_idx_r;
  assign out_last_word   = out_valid_r && out_last_r;

endmodule

// ----- rtl/dite_checker.sv -----
// Port checker for the data island encoder, bound to the top level.
module dite_checker
  import dite_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [WORD_W-1:0] out_symbol_word,
  input logic [IDX_W-1:0]  out_word_index,
  input logic              out_last_word
);

  // a transfer starts an island at word 0 after the packet and output registers
  a_start_first: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> ##1 (out_valid && out_word_index == '0))
    else $error("island did not start at word 0");

  // words of one island come back to back in order
  a_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_index != IDX_LAST |=>
      out_valid && out_word_index == $past(out_word_index) + 6'd1)
    else $error("island words out of order or gapped");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_word |-> out_valid && out_word_index == IDX_LAST)
    else $error("last_word on wrong word");

  // next packet is taken while the island tail is still going out
  a_free_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word_index == (IDX_LAST - 6'd1) |-> !busy)
    else $error("busy held through island tail");

  a_guard_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word_index == '0 || out_word_index == IDX_LAST) |->
      out_symbol_word[WORD_W-1:LANE_W] == {GUARD_SYMBOL, GUARD_SYMBOL})
    else $error("guard word lanes 1/2 wrong");

endmodule

bind data_island_terc4_encoder_core dite_checker u_dite_checker (.*);
